// ===== rtl/core/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg
// Types, constants and calendar helper functions for the month grid block.
// ----------------------------------------------------------------------------
package mcg_pkg;

  // Grid geometry: six weeks of seven days.
  localparam int unsigned GRID_CELLS = 42;
  localparam int unsigned CELL_W     = 6;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CFG_W   = 14;

  // Year limits and reset view.
  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2026;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd9;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd3;
  // First weekday and lengths of the reset month and the month before it.
  localparam logic [2:0]         RESET_FD    = 3'd2;
  localparam logic [DAY_W-1:0]   RESET_DIM   = 5'd30;
  localparam logic [DAY_W-1:0]   RESET_DPREV = 5'd31;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for any 14-bit y.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned PROD_W       = 27;

  typedef enum logic [1:0] {
    OP_PREV   = 2'd0,
    OP_NEXT   = 2'd1,
    OP_TODAY  = 2'd2,
    OP_SELECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_PREV = 2'd0,
    KIND_CUR  = 2'd1,
    KIND_NEXT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TODAY_YEAR  = 2'd0,
    CFG_TODAY_MONTH = 2'd1,
    CFG_TODAY_DAY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CALC1,
    FS_CALC2,
    FS_CALC3,
    FS_PUSH
  } front_state_e;

  // One grid to be drawn.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [2:0]         first_wd;
    logic [DAY_W-1:0]   dim;
    logic [DAY_W-1:0]   dprev;
    logic [DAY_W-1:0]   sel_day;
  } job_t;

  // Current today registers as seen by the front and back.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } today_t;

  // Sakamoto month offsets.
  function automatic logic [2:0] wd_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        r = 5'd31;
      default:                   r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mcg_job_fifo.sv =====
// ----------------------------------------------------------------------------
// mcg_job_fifo
// Two-entry queue of grid jobs between the event front end and the cell
// emitter.
// ----------------------------------------------------------------------------
module mcg_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcg_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mcg_pkg::job_t pop_data_o
);

  mcg_pkg::job_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/mcg_front.sv =====
// ----------------------------------------------------------------------------
// mcg_front
// Takes events, updates the viewed month and selection, and works out the
// first weekday and month lengths before queueing a grid job.
// ----------------------------------------------------------------------------
module mcg_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ev_valid_i,
  output logic                            ev_ready_o,
  input  mcg_pkg::op_e                    ev_op_i,
  input  logic [mcg_pkg::CELL_W-1:0]      ev_cell_i,
  input  mcg_pkg::today_t                 today_i,
  output logic                            job_push_o,
  output mcg_pkg::job_t                   job_o,
  input  logic                            job_full_i
);

  mcg_pkg::front_state_e state_q, state_d;

  logic [mcg_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [mcg_pkg::MONTH_W-1:0] month_q, month_d;
  logic [mcg_pkg::DAY_W-1:0]   sel_q, sel_d;
  logic [2:0]                  fd_q, fd_d;
  logic [mcg_pkg::DAY_W-1:0]   dim_q, dim_d;
  logic [mcg_pkg::DAY_W-1:0]   dprev_q, dprev_d;

  // Arithmetic pipeline registers.
  logic [mcg_pkg::YEAR_W-1:0]  yy_q;
  logic [mcg_pkg::PROD_W-1:0]  prod_q;
  logic [mcg_pkg::PROD_W-1:0]  prod_y_q;
  logic [14:0]                 sum_q;

  logic                        accept;
  logic [mcg_pkg::YEAR_W-1:0]  yy;
  logic [7:0]                  q100;
  logic [7:0]                  q100_y;
  logic [14:0]                 sum_d;
  logic [5:0]                  fold1;
  logic [3:0]                  fold2;
  logic [2:0]                  fd_new;
  logic                        div100;
  logic                        leap;
  logic [mcg_pkg::MONTH_W-1:0] prev_month;
  logic [6:0]                  cell7;
  logic [6:0]                  fd7;
  logic [6:0]                  end7;
  logic [6:0]                  sel7;
  logic                        today_ok;

  assign ev_ready_o = (state_q == mcg_pkg::FS_IDLE);
  assign accept     = ev_valid_i && ev_ready_o;

  // Sakamoto uses the previous year for January and February.
  assign yy = (month_q < 4'd3) ? (year_q - 14'd1) : year_q;

  assign q100   = prod_q[mcg_pkg::DIV100_SHIFT +: 8];
  assign q100_y = prod_y_q[mcg_pkg::DIV100_SHIFT +: 8];

  assign sum_d = {1'b0, yy_q} + {3'b000, yy_q[13:2]} - {7'd0, q100}
               + {9'd0, q100[7:2]} + {12'd0, mcg_pkg::wd_offset(month_q)} + 15'd1;

  // Base-8 digit folding gives the value modulo 7.
  assign fold1  = {3'd0, sum_q[2:0]} + {3'd0, sum_q[5:3]} + {3'd0, sum_q[8:6]}
                + {3'd0, sum_q[11:9]} + {3'd0, sum_q[14:12]};
  assign fold2  = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
  assign fd_new = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  assign div100 = (year_q == 14'(q100_y * 7'd100));
  assign leap   = (year_q[1:0] == 2'b00) && (!div100 || (q100_y[1:0] == 2'b00));
  assign prev_month = (month_q == 4'd1) ? 4'd12 : (month_q - 4'd1);

  assign cell7 = {1'b0, ev_cell_i};
  assign fd7   = {4'd0, fd_q};
  assign end7  = fd7 + {2'd0, dim_q};
  assign sel7  = cell7 - fd7 + 7'd1;

  assign today_ok = (today_i.year >= mcg_pkg::YEAR_MIN) && (today_i.year <= mcg_pkg::YEAR_MAX)
                 && (today_i.month >= 4'd1) && (today_i.month <= 4'd12);

  assign job_push_o     = (state_q == mcg_pkg::FS_PUSH);
  assign job_o.year     = year_q;
  assign job_o.month    = month_q;
  assign job_o.first_wd = fd_q;
  assign job_o.dim      = dim_q;
  assign job_o.dprev    = dprev_q;
  assign job_o.sel_day  = sel_q;

  always_comb begin
    state_d = state_q;
    year_d  = year_q;
    month_d = month_q;
    sel_d   = sel_q;
    fd_d    = fd_q;
    dim_d   = dim_q;
    dprev_d = dprev_q;
    case (state_q)
      mcg_pkg::FS_IDLE: begin
        if (accept) begin
          case (ev_op_i)
            mcg_pkg::OP_PREV: begin
              if (month_q <= 4'd1) begin
                if (year_q > mcg_pkg::YEAR_MIN) begin
                  month_d = 4'd12;
                  year_d  = year_q - 14'd1;
                  sel_d   = '0;
                  state_d = mcg_pkg::FS_CALC1;
                end
              end else begin
                month_d = month_q - 4'd1;
                sel_d   = '0;
                state_d = mcg_pkg::FS_CALC1;
              end
            end
            mcg_pkg::OP_NEXT: begin
              if (month_q >= 4'd12) begin
                if (year_q < mcg_pkg::YEAR_MAX) begin
                  month_d = 4'd1;
                  year_d  = year_q + 14'd1;
                  sel_d   = '0;
                  state_d = mcg_pkg::FS_CALC1;
                end
              end else begin
                month_d = month_q + 4'd1;
                sel_d   = '0;
                state_d = mcg_pkg::FS_CALC1;
              end
            end
            mcg_pkg::OP_TODAY: begin
              if (today_ok) begin
                year_d  = today_i.year;
                month_d = today_i.month;
                sel_d   = today_i.day;
                state_d = mcg_pkg::FS_CALC1;
              end
            end
            mcg_pkg::OP_SELECT: begin
              // Only a cell of the viewed month is a valid selection.
              if ((cell7 < 7'(mcg_pkg::GRID_CELLS)) && (cell7 >= fd7) && (cell7 < end7)) begin
                sel_d   = sel7[mcg_pkg::DAY_W-1:0];
                state_d = mcg_pkg::FS_PUSH;
              end
            end
            default: begin
              state_d = mcg_pkg::FS_IDLE;
            end
          endcase
        end
      end
      mcg_pkg::FS_CALC1: state_d = mcg_pkg::FS_CALC2;
      mcg_pkg::FS_CALC2: state_d = mcg_pkg::FS_CALC3;
      mcg_pkg::FS_CALC3: begin
        fd_d    = fd_new;
        dim_d   = mcg_pkg::month_days(month_q, leap);
        dprev_d = mcg_pkg::month_days(prev_month, leap);
        state_d = mcg_pkg::FS_PUSH;
      end
      mcg_pkg::FS_PUSH: begin
        if (!job_full_i) begin
          state_d = mcg_pkg::FS_IDLE;
        end
      end
      default: state_d = mcg_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcg_pkg::FS_IDLE;
      year_q  <= mcg_pkg::RESET_YEAR;
      month_q <= mcg_pkg::RESET_MONTH;
      sel_q   <= '0;
      fd_q    <= mcg_pkg::RESET_FD;
      dim_q   <= mcg_pkg::RESET_DIM;
      dprev_q <= mcg_pkg::RESET_DPREV;
    end else begin
      state_q <= state_d;
      year_q  <= year_d;
      month_q <= month_d;
      sel_q   <= sel_d;
      fd_q    <= fd_d;
      dim_q   <= dim_d;
      dprev_q <= dprev_d;
    end
  end

  // One constant multiply per stage: year offset first, then leap test.
  always_ff @(posedge clk_i) begin
    if (state_q == mcg_pkg::FS_CALC1) begin
      yy_q   <= yy;
      prod_q <= mcg_pkg::PROD_W'(yy * mcg_pkg::DIV100_MUL);
    end
    if (state_q == mcg_pkg::FS_CALC2) begin
      sum_q    <= sum_d;
      prod_y_q <= mcg_pkg::PROD_W'(year_q * mcg_pkg::DIV100_MUL);
    end
  end

endmodule

// ===== rtl/core/mcg_back.sv =====
// ----------------------------------------------------------------------------
// mcg_back
// Walks each queued grid into an output register, one cell per unstalled cycle.
// ----------------------------------------------------------------------------
module mcg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  mcg_pkg::job_t               job_i,
  output logic                        job_pop_o,
  input  mcg_pkg::today_t             today_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mcg_pkg::CELL_W-1:0]  cell_number_o,
  output logic [mcg_pkg::DAY_W-1:0]   day_number_o,
  output mcg_pkg::kind_e              cell_kind_o,
  output logic                        today_flag_o,
  output logic                        sel_flag_o,
  output logic [mcg_pkg::YEAR_W-1:0]  shown_year_o,
  output logic [mcg_pkg::MONTH_W-1:0] shown_month_o,
  output logic                        last_o
);

  logic                        active_q;
  mcg_pkg::job_t               job_q;
  logic [mcg_pkg::CELL_W-1:0]  idx_q;
  logic                        out_valid_q;

  logic [mcg_pkg::CELL_W-1:0]  cell_q;
  logic [mcg_pkg::DAY_W-1:0]   day_q, day_d;
  mcg_pkg::kind_e              kind_q, kind_d;
  logic                        today_q, today_d;
  logic                        sel_q, sel_d;
  logic [mcg_pkg::YEAR_W-1:0]  year_q;
  logic [mcg_pkg::MONTH_W-1:0] month_q;
  logic                        last_q;

  logic       can_load;
  logic       adv;
  logic       last_cell;
  logic       take;
  logic [6:0] i7, fd7, end7, d7;
  logic       today_view;

  assign can_load  = !out_valid_q || out_ready_i;
  assign adv       = active_q && can_load;
  assign last_cell = (idx_q == mcg_pkg::CELL_W'(mcg_pkg::GRID_CELLS - 1));
  // The next job is taken in the cycle the last cell of the current one goes out.
  assign take      = job_valid_i && (!active_q || (adv && last_cell));
  assign job_pop_o = take;

  assign i7   = {1'b0, idx_q};
  assign fd7  = {4'd0, job_q.first_wd};
  assign end7 = fd7 + {2'd0, job_q.dim};
  assign today_view = (job_q.year == today_i.year) && (job_q.month == today_i.month);

  always_comb begin
    today_d = 1'b0;
    sel_d   = 1'b0;
    if (i7 < fd7) begin
      d7     = {2'd0, job_q.dprev} + 7'd1 + i7 - fd7;
      kind_d = mcg_pkg::KIND_PREV;
    end else if (i7 < end7) begin
      d7      = i7 - fd7 + 7'd1;
      kind_d  = mcg_pkg::KIND_CUR;
      today_d = today_view && (d7[mcg_pkg::DAY_W-1:0] == today_i.day) && (d7[6:5] == 2'd0);
      sel_d   = (d7[mcg_pkg::DAY_W-1:0] == job_q.sel_day) && (d7[6:5] == 2'd0);
    end else begin
      d7     = i7 - end7 + 7'd1;
      kind_d = mcg_pkg::KIND_NEXT;
    end
    day_d = d7[mcg_pkg::DAY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (adv && last_cell) begin
        active_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + mcg_pkg::CELL_W'(1);
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_i;
    end
    if (adv) begin
      cell_q  <= idx_q;
      day_q   <= day_d;
      kind_q  <= kind_d;
      today_q <= today_d;
      sel_q   <= sel_d;
      year_q  <= job_q.year;
      month_q <= job_q.month;
      last_q  <= last_cell;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_number_o = cell_q;
  assign day_number_o  = day_q;
  assign cell_kind_o   = kind_q;
  assign today_flag_o  = today_q;
  assign sel_flag_o    = sel_q;
  assign shown_year_o  = year_q;
  assign shown_month_o = month_q;
  assign last_o        = last_q;

endmodule

// ===== rtl/core/month_calendar_grid.sv =====
// ----------------------------------------------------------------------------
// month_calendar_grid
// Month view calendar: navigation and selection events in, one result per
// cell of the six-week, Sunday-first grid out.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_axis   in         tuser: opcode; tdata: cell_index
//  m_axis   out        tuser: cell_kind; tdata: cell, day, flags, year, month;
//                      tlast: final cell of the grid
//  cfg      in         write of today_year, today_month or today_day
//
// A grid goes out one cell per cycle while m_axis does not stall, set by the
// cell emitter. A navigation event passes FS_CALC1 to FS_CALC3 (two constant
// multiplies for the weekday and leap year) and FS_PUSH, a select only FS_PUSH;
// the front end works ahead through a two-entry job queue and stays idle on an
// ignored event. Reset puts the view on September 2026 with nothing selected.
// A stall on m_axis holds the current cell in the output register.
// ----------------------------------------------------------------------------
module month_calendar_grid (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [5:0] cell_index
  input  logic [1:0]                   s_axis_tuser,   // [1:0] opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [5:0] cell_number, [10:6] day_number, [11] today flag, [12] selected flag,
  // [26:13] shown_year, [30:27] shown_month, [31] zero
  output logic [31:0]                  m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,   // [1:0] cell_kind
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_addr_i,
  input  logic [mcg_pkg::CFG_W-1:0]    cfg_wdata_i
);

  mcg_pkg::today_t             today_q;
  mcg_pkg::job_t               front_job;
  mcg_pkg::job_t               fifo_job;
  logic                        job_push, job_full, job_valid, job_pop;
  logic [mcg_pkg::CELL_W-1:0]  cell_number;
  logic [mcg_pkg::DAY_W-1:0]   day_number;
  mcg_pkg::kind_e              cell_kind;
  logic                        today_flag, sel_flag;
  logic [mcg_pkg::YEAR_W-1:0]  shown_year;
  logic [mcg_pkg::MONTH_W-1:0] shown_month;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      today_q.year  <= mcg_pkg::RESET_YEAR;
      today_q.month <= mcg_pkg::RESET_MONTH;
      today_q.day   <= mcg_pkg::RESET_DAY;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mcg_pkg::CFG_TODAY_YEAR:  today_q.year  <= cfg_wdata_i[mcg_pkg::YEAR_W-1:0];
        mcg_pkg::CFG_TODAY_MONTH: today_q.month <= cfg_wdata_i[mcg_pkg::MONTH_W-1:0];
        mcg_pkg::CFG_TODAY_DAY:   today_q.day   <= cfg_wdata_i[mcg_pkg::DAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (s_axis_tvalid),
    .ev_ready_o (s_axis_tready),
    .ev_op_i    (mcg_pkg::op_e'(s_axis_tuser)),
    .ev_cell_i  (s_axis_tdata[mcg_pkg::CELL_W-1:0]),
    .today_i    (today_q),
    .job_push_o (job_push),
    .job_o      (front_job),
    .job_full_i (job_full)
  );

  mcg_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (front_job),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .pop_data_o  (fifo_job)
  );

  mcg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (fifo_job),
    .job_pop_o     (job_pop),
    .today_i       (today_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .cell_number_o (cell_number),
    .day_number_o  (day_number),
    .cell_kind_o   (cell_kind),
    .today_flag_o  (today_flag),
    .sel_flag_o    (sel_flag),
    .shown_year_o  (shown_year),
    .shown_month_o (shown_month),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, shown_month, shown_year, sel_flag, today_flag,
                         day_number, cell_number};
  assign m_axis_tuser = cell_kind;

endmodule

// ===== verif/month_calendar_grid_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// month_calendar_grid_tb
// Drives navigation and cell selection events into the month grid block and
// checks every emitted cell against a grid worked out alongside the stimulus.
// Directed tests cover selection edges, navigation, the today registers and
// the year limits; a random phase follows with the today registers changed
// between batches. The output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module month_calendar_grid_tb;

  localparam int unsigned WATCHDOG_CYCLES = 1000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned TOTAL_ITEMS     = 210;

  // Sakamoto month offsets and month lengths of a common year.
  localparam int unsigned SAKAMOTO_OFS[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int unsigned COMMON_LEN[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [mcg_pkg::CELL_W-1:0]  cell_no;
    logic [mcg_pkg::DAY_W-1:0]   day;
    mcg_pkg::kind_e              kind;
    logic                        today;
    logic                        sel;
    logic [mcg_pkg::YEAR_W-1:0]  year;
    logic [mcg_pkg::MONTH_W-1:0] month;
    logic                        last;
  } cell_exp_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;
  logic [1:0]                s_axis_tuser  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [31:0]               m_axis_tdata;
  logic [1:0]                m_axis_tuser;
  logic                      m_axis_tlast;
  logic                      cfg_we_i      = 1'b0;
  logic [1:0]                cfg_addr_i    = '0;
  logic [mcg_pkg::CFG_W-1:0] cfg_wdata_i   = '0;

  // Predicted view and today registers.
  int unsigned view_y = 2026, view_m = 9, sel_day = 0;
  int unsigned today_y = 2026, today_m = 9, today_d = 3;

  cell_exp_t   grid_q[$];
  int unsigned items_sent = 0;
  int unsigned n_fail     = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_mode = 0, rx_mode_left = 0, rx_stall = 0;

  month_calendar_grid i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    if (m == 2 && leap_year(y)) return 29;
    return COMMON_LEN[m-1];
  endfunction

  // January and February count as months of the previous year.
  function automatic int unsigned first_weekday_of(int unsigned y, int unsigned m);
    int unsigned yy;
    yy = (m < 3) ? y - 1 : y;
    return (yy + yy / 4 - yy / 100 + yy / 400 + SAKAMOTO_OFS[m-1] + 1) % 7;
  endfunction

  function automatic void push_month_grid();
    int unsigned fd, dim, dprev, d;
    bit          today_view;
    cell_exp_t   c;
    fd         = first_weekday_of(view_y, view_m);
    dim        = month_length(view_y, view_m);
    dprev      = (view_m == 1) ? 31 : month_length(view_y, view_m - 1);
    today_view = (view_y == today_y) && (view_m == today_m);
    for (int unsigned i = 0; i < mcg_pkg::GRID_CELLS; i++) begin
      c.today = 1'b0;
      c.sel   = 1'b0;
      if (i < fd) begin
        d      = dprev - fd + 1 + i;
        c.kind = mcg_pkg::KIND_PREV;
      end else if (i < fd + dim) begin
        d       = i - fd + 1;
        c.kind  = mcg_pkg::KIND_CUR;
        c.today = today_view && (d == today_d);
        c.sel   = (d == sel_day);
      end else begin
        d      = i - fd - dim + 1;
        c.kind = mcg_pkg::KIND_NEXT;
      end
      c.cell_no = mcg_pkg::CELL_W'(i);
      c.day     = mcg_pkg::DAY_W'(d);
      c.year    = mcg_pkg::YEAR_W'(view_y);
      c.month   = mcg_pkg::MONTH_W'(view_m);
      c.last    = (i == mcg_pkg::GRID_CELLS - 1);
      grid_q.push_back(c);
    end
  endfunction

  // Updates the view for one accepted event and queues its grid, if any.
  function automatic void apply_event(mcg_pkg::op_e op, int unsigned cell_idx);
    int unsigned fd, dim;
    case (op)
      mcg_pkg::OP_PREV: begin
        if (view_m <= 1) begin
          if (view_y <= 1) return;
          view_m = 12;
          view_y--;
        end else begin
          view_m--;
        end
        sel_day = 0;
      end
      mcg_pkg::OP_NEXT: begin
        if (view_m >= 12) begin
          if (view_y >= 9999) return;
          view_m = 1;
          view_y++;
        end else begin
          view_m++;
        end
        sel_day = 0;
      end
      mcg_pkg::OP_TODAY: begin
        if (today_y < 1 || today_y > 9999 || today_m < 1 || today_m > 12) return;
        view_y  = today_y;
        view_m  = today_m;
        sel_day = today_d;
      end
      default: begin
        fd  = first_weekday_of(view_y, view_m);
        dim = month_length(view_y, view_m);
        if (cell_idx >= mcg_pkg::GRID_CELLS || cell_idx < fd || cell_idx >= fd + dim) return;
        sel_day = cell_idx - fd + 1;
      end
    endcase
    push_month_grid();
  endfunction

  // Called and left at a falling edge. The valid stays high within a burst.
  task automatic send_event(input mcg_pkg::op_e op, input logic [mcg_pkg::CELL_W-1:0] cell_idx);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, cell_idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_event(op, cell_idx);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_grid_done();
    s_axis_tvalid <= 1'b0;
    while (grid_q.size() != 0) @(posedge clk_i);
    // Extra settle time; an ignored event leaves nothing in the front end.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_today(input int unsigned y, input int unsigned m, input int unsigned d);
    wait_grid_done();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= mcg_pkg::CFG_TODAY_YEAR;
    cfg_wdata_i <= mcg_pkg::CFG_W'(y);
    @(negedge clk_i);
    cfg_addr_i  <= mcg_pkg::CFG_TODAY_MONTH;
    cfg_wdata_i <= mcg_pkg::CFG_W'(m);
    @(negedge clk_i);
    cfg_addr_i  <= mcg_pkg::CFG_TODAY_DAY;
    cfg_wdata_i <= mcg_pkg::CFG_W'(d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    today_y = y & 'h3FFF;
    today_m = m & 'hF;
    today_d = d & 'h1F;
    @(negedge clk_i);
  endtask

  // Reset view is September 2026: the 1st falls in cell 2, the 30th in cell 31.
  task automatic test_select_cells();
    send_event(mcg_pkg::OP_SELECT, 6'd0);
    send_event(mcg_pkg::OP_SELECT, 6'd2);
    send_event(mcg_pkg::OP_SELECT, 6'd31);
    send_event(mcg_pkg::OP_SELECT, 6'd32);
    send_event(mcg_pkg::OP_SELECT, 6'd41);
    send_event(mcg_pkg::OP_SELECT, 6'd42);
    send_event(mcg_pkg::OP_SELECT, 6'd63);
    send_event(mcg_pkg::OP_SELECT, 6'd21);
  endtask

  task automatic test_navigation();
    send_event(mcg_pkg::OP_NEXT, 6'd0);
    send_event(mcg_pkg::OP_PREV, 6'd63);
    send_event(mcg_pkg::OP_PREV, 6'd0);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
  endtask

  task automatic test_today_registers();
    set_today(2024, 2, 29);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    set_today(1900, 2, 29);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    set_today(2000, 3, 0);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    // Out-of-range year or month: the jump is dropped and the view kept.
    set_today(0, 5, 5);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    set_today(16383, 15, 31);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    send_event(mcg_pkg::OP_SELECT, 6'd10);
  endtask

  task automatic test_year_limits();
    set_today(1, 1, 1);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    send_event(mcg_pkg::OP_PREV, 6'd0);
    send_event(mcg_pkg::OP_NEXT, 6'd0);
    set_today(9999, 12, 31);
    send_event(mcg_pkg::OP_TODAY, 6'd0);
    send_event(mcg_pkg::OP_NEXT, 6'd0);
    send_event(mcg_pkg::OP_PREV, 6'd0);
  endtask

  task automatic test_random_events();
    int unsigned y, m, r, fd, dim, n;
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 11);
      y = (r == 0) ? 1 : (r == 1) ? 9999 : (r == 2) ? 0 :
          (r == 3) ? $urandom_range(10000, 16383) : $urandom_range(1, 9999);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 15) * $urandom_range(0, 1)
                                      : $urandom_range(1, 12);
      set_today(y, m, $urandom_range(0, 31));
      n = $urandom_range(10, 40);
      for (int unsigned k = 0; (k < n) && (items_sent < TOTAL_ITEMS); k++) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          send_event(mcg_pkg::OP_PREV, 6'($urandom_range(0, 63)));
        end else if (r < 40) begin
          send_event(mcg_pkg::OP_NEXT, 6'($urandom_range(0, 63)));
        end else if (r < 55) begin
          send_event(mcg_pkg::OP_TODAY, 6'($urandom_range(0, 63)));
        end else begin
          fd  = first_weekday_of(view_y, view_m);
          dim = month_length(view_y, view_m);
          if ($urandom_range(0, 4) != 0)
            send_event(mcg_pkg::OP_SELECT, 6'(fd + $urandom_range(0, dim - 1)));
          else
            send_event(mcg_pkg::OP_SELECT, 6'($urandom_range(0, 63)));
        end
      end
    end
  endtask

  // Output side: free running, random per cycle, or bursts of long stalls.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall != 0) begin
          m_axis_tready <= 1'b0;
          rx_stall--;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 20);
        end
      end
    endcase
  end

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    cell_exp_t c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grid_q.size() == 0) begin
        $error("cell transaction with no grid expected");
        n_fail++;
      end else begin
        c = grid_q.pop_front();
        check_field("cell_number", c.cell_no, m_axis_tdata[5:0]);
        check_field("day_number", c.day, m_axis_tdata[10:6]);
        check_field("today_flag", c.today, m_axis_tdata[11]);
        check_field("selected_flag", c.sel, m_axis_tdata[12]);
        check_field("shown_year", c.year, m_axis_tdata[26:13]);
        check_field("shown_month", c.month, m_axis_tdata[30:27]);
        check_field("cell_kind", c.kind, m_axis_tuser);
        check_field("last", c.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_select_cells();
    test_navigation();
    test_today_registers();
    test_year_limits();
    test_random_events();
    wait_grid_done();
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
